/* hw/rtl/periodic_task_timer_table_unit_macros.svh */
// Assertion helpers, clocked on clk and quiet while arst_n is low.
`ifndef PERIODIC_TASK_TIMER_TABLE_UNIT_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define PTT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptt: same-cycle check failed");

// Next-cycle implication.
`define PTT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptt: next-cycle check failed");

`endif

/* hw/rtl/ptt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

	localparam int TASK_SLOTS  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(TASK_SLOTS + 1);
	localparam int FC_W        = $clog2(MAX_RESULTS + 1);
	localparam int RC_W        = 5;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_ADD  = 2'd1;
	localparam logic [1:0] CMD_DEL  = 2'd2;
	localparam logic [1:0] CMD_RSVD = 2'd3;

	localparam logic [2:0] KIND_FIRED   = 3'd0;
	localparam logic [2:0] KIND_ADDED   = 3'd1;
	localparam logic [2:0] KIND_FULL    = 3'd2;
	localparam logic [2:0] KIND_BAD_PER = 3'd3;
	localparam logic [2:0] KIND_DELETED = 3'd4;

	typedef struct packed {
		logic [15:0]        key;
		logic [15:0]        opcode;
		logic [15:0]        period;
		logic [15:0]        elapsed;
		logic signed [15:0] remaining;
	} slot_data_t;

	typedef struct packed {
		logic       valid;
		slot_data_t data;
	} slot_t;

	// Request held for the whole sweep, plus the add's slot-claimed flag.
	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        key;
		logic [15:0]        opcode;
		logic [15:0]        period;
		logic signed [15:0] repeat_count;
		logic               found;
	} op_t;

	typedef struct packed {
		logic fire;
		logic claim;
		logic hit;
	} slot_flags_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/ptt_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ptt_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [15:0]        task_key;
	logic [15:0]        task_opcode;
	logic [15:0]        period;
	logic signed [15:0] repeat_count;

	modport source (
		output valid, cmd, task_key, task_opcode, period, repeat_count,
		input  ready
	);
	modport sink (
		input  valid, cmd, task_key, task_opcode, period, repeat_count,
		output ready
	);
endinterface

`default_nettype wire

/* hw/rtl/ptt_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ptt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] out_key;
	logic [15:0] out_opcode;
	logic [4:0]  removed_count;
	logic        last;

	modport source (
		output valid, kind, out_key, out_opcode, removed_count, last,
		input  ready
	);
	modport sink (
		input  valid, kind, out_key, out_opcode, removed_count, last,
		output ready
	);
endinterface

`default_nettype wire

/* hw/rtl/ptt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptt_cell
	import ptt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  shift,
	input  wire slot_t d,
	output slot_t      q
);

	logic       valid_q;
	slot_data_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d.data;
		end
	end

	assign q.valid = valid_q;
	assign q.data  = data_q;

endmodule

`default_nettype wire

/* hw/rtl/ptt_slot_upd.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptt_slot_upd
	import ptt_pkg::*;
(
	input  wire op_t   op,
	input  wire slot_t cur,
	output slot_t       nxt,
	output slot_flags_t flags
);

	logic [15:0] elapsed_inc;

	assign elapsed_inc = cur.data.elapsed + 16'd1;

	always_comb begin
		nxt   = cur;
		flags = '0;
		case (op.cmd)
			CMD_TICK: begin
				if (cur.valid) begin
					if (cur.data.remaining == 16'sd0) begin
						nxt.valid = 1'b0;
					end else begin
						nxt.data.elapsed = elapsed_inc;
						if (elapsed_inc == cur.data.period) begin
							flags.fire       = 1'b1;
							nxt.data.elapsed = '0;
							if (cur.data.remaining > 16'sd0) begin
								nxt.data.remaining = cur.data.remaining - 16'sd1;
							end
						end
						if (nxt.data.remaining == 16'sd0) begin
							nxt.valid = 1'b0;
						end
					end
				end
			end
			CMD_ADD: begin
				if (op.period != 16'd0 && !op.found && !cur.valid) begin
					flags.claim        = 1'b1;
					nxt.valid          = 1'b1;
					nxt.data.key       = op.key;
					nxt.data.opcode    = op.opcode;
					nxt.data.period    = op.period;
					nxt.data.elapsed   = '0;
					nxt.data.remaining = op.repeat_count;
				end
			end
			CMD_DEL: begin
				if (cur.valid && cur.data.key == op.key && cur.data.opcode == op.opcode) begin
					flags.hit = 1'b1;
					nxt.valid = 1'b0;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/periodic_task_timer_table_unit.sv */
// Channel | Dir | Handshake     | Payload
// req     | in  | valid / ready | cmd, task_key, task_opcode, period, repeat_count
// rsp     | out | valid / ready | kind, out_key, out_opcode, removed_count, last
//
// Each tick, add or delete holds req.ready low once it is taken, until the sweep ends:
// the slot ring rotates once through the single update unit at its head, then one
// closing step issues the final response, if any. The block takes no new request
// until then. Command code 3 is taken while idle and gives nothing.
// A response waiting on rsp.ready stalls the rotation only where a new one is due.
// arst_n clears all valid bits and control; one request at a time.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_task_timer_table_unit_macros.svh"

module periodic_task_timer_table_unit
	import ptt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	ptt_req_if.sink   req,
	ptt_rsp_if.source rsp
);

	localparam int EXT_W = CNT_W + RC_W;

	state_t             state_q;
	logic [CNT_W-1:0]   step_q;
	logic [FC_W-1:0]    fire_cnt_q;
	logic [CNT_W-1:0]   del_cnt_q;
	logic               found_q;
	logic               pend_valid_q;
	logic [15:0]        pend_key_q;
	logic [15:0]        pend_opcode_q;
	logic [1:0]         cmd_q;
	logic [15:0]        key_q;
	logic [15:0]        opcode_q;
	logic [15:0]        period_q;
	logic signed [15:0] repeat_q;

	logic               out_valid_q;
	logic [2:0]         out_kind_q;
	logic [15:0]        out_key_q;
	logic [15:0]        out_opcode_q;
	logic [RC_W-1:0]    out_removed_q;
	logic               out_last_q;

	slot_t       ring [TASK_SLOTS];
	slot_t       head_nxt;
	slot_flags_t head_flags;
	op_t         op;

	logic             accept;
	logic             sweeping;
	logic             at_flush;
	logic             record;
	logic             emit;
	logic             out_free;
	logic             advance;
	logic             shift;
	logic [2:0]       emit_kind;
	logic [15:0]      emit_key;
	logic [15:0]      emit_opcode;
	logic [RC_W-1:0]  emit_removed;
	logic             emit_last;
	logic [EXT_W-1:0] del_ext;

	assign op.cmd          = cmd_q;
	assign op.key          = key_q;
	assign op.opcode       = opcode_q;
	assign op.period       = period_q;
	assign op.repeat_count = repeat_q;
	assign op.found        = found_q;

	genvar gi;
	generate
		for (gi = 0; gi < TASK_SLOTS; gi++) begin : g_cell
			if (gi == TASK_SLOTS - 1) begin : g_tail
				ptt_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (shift),
					.d      (head_nxt),
					.q      (ring[gi])
				);
			end else begin : g_body
				ptt_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (shift),
					.d      (ring[gi+1]),
					.q      (ring[gi])
				);
			end
		end
	endgenerate

	ptt_slot_upd u_upd (
		.op    (op),
		.cur   (ring[0]),
		.nxt   (head_nxt),
		.flags (head_flags)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign sweeping  = (state_q == ST_SWEEP);
	assign at_flush  = (step_q == CNT_W'(TASK_SLOTS));
	assign record    = head_flags.fire && (fire_cnt_q < FC_W'(MAX_RESULTS));
	assign out_free  = !out_valid_q || rsp.ready;
	assign del_ext   = EXT_W'(del_cnt_q);

	always_comb begin
		emit         = 1'b0;
		emit_kind    = KIND_FIRED;
		emit_key     = pend_key_q;
		emit_opcode  = pend_opcode_q;
		emit_removed = '0;
		emit_last    = 1'b0;
		if (!at_flush) begin
			emit = (cmd_q == CMD_TICK) && record && pend_valid_q;
		end else begin
			emit_last = 1'b1;
			case (cmd_q)
				CMD_TICK: begin
					emit = pend_valid_q;
				end
				CMD_ADD: begin
					emit        = 1'b1;
					emit_key    = key_q;
					emit_opcode = opcode_q;
					if (period_q == 16'd0) begin
						emit_kind = KIND_BAD_PER;
					end else if (found_q) begin
						emit_kind = KIND_ADDED;
					end else begin
						emit_kind = KIND_FULL;
					end
				end
				CMD_DEL: begin
					emit        = 1'b1;
					emit_kind   = KIND_DELETED;
					emit_key    = key_q;
					emit_opcode = opcode_q;
					if (del_ext > EXT_W'({RC_W{1'b1}})) begin
						emit_removed = {RC_W{1'b1}};
					end else begin
						emit_removed = del_ext[RC_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	assign advance = sweeping && (!emit || out_free);
	assign shift   = advance && !at_flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			fire_cnt_q   <= '0;
			del_cnt_q    <= '0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && req.cmd != CMD_RSVD) begin
						state_q      <= ST_SWEEP;
						step_q       <= '0;
						fire_cnt_q   <= '0;
						del_cnt_q    <= '0;
						found_q      <= 1'b0;
						pend_valid_q <= 1'b0;
					end
				end
				ST_SWEEP: begin
					if (advance) begin
						if (at_flush) begin
							state_q      <= ST_IDLE;
							pend_valid_q <= 1'b0;
						end else begin
							step_q  <= step_q + CNT_W'(1);
							found_q <= found_q || head_flags.claim;
							if (head_flags.hit) begin
								del_cnt_q <= del_cnt_q + CNT_W'(1);
							end
							if (cmd_q == CMD_TICK && record) begin
								pend_valid_q <= 1'b1;
								fire_cnt_q   <= fire_cnt_q + FC_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.cmd;
			key_q    <= req.task_key;
			opcode_q <= req.task_opcode;
			period_q <= req.period;
			repeat_q <= req.repeat_count;
		end
		if (shift && cmd_q == CMD_TICK && record) begin
			pend_key_q    <= ring[0].data.key;
			pend_opcode_q <= ring[0].data.opcode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_kind_q    <= emit_kind;
			out_key_q     <= emit_key;
			out_opcode_q  <= emit_opcode;
			out_removed_q <= emit_removed;
			out_last_q    <= emit_last;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.kind          = out_kind_q;
	assign rsp.out_key       = out_key_q;
	assign rsp.out_opcode    = out_opcode_q;
	assign rsp.removed_count = out_removed_q;
	assign rsp.last          = out_last_q;

	`PTT_ASSERT_IMP(a_step_bound, sweeping, step_q <= CNT_W'(TASK_SLOTS))
	`PTT_ASSERT_IMP(a_fire_bound, 1'b1, fire_cnt_q <= FC_W'(MAX_RESULTS))
	`PTT_ASSERT_IMP(a_pend_in_sweep, pend_valid_q, sweeping)
	`PTT_ASSERT_NXT(a_busy_after_req, accept && req.cmd != CMD_RSVD, !req.ready)
	`PTT_ASSERT_IMP(a_no_shift_at_flush, at_flush && sweeping, !shift)

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb
	import ptt_pkg::*;
();

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_REQS = 245;
	localparam int CALM_TAIL = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER = 80;
	localparam int DRAIN_CYCLES = 40;
	localparam logic signed [15:0] REPEAT_FOREVER = -16'sd1;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        key;
		logic [15:0]        opcode;
		logic [15:0]        period;
		logic signed [15:0] rep;
	} timer_req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] key;
		logic [15:0] opcode;
		logic [4:0]  removed;
		logic        last;
	} timer_evt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	ptt_req_if req ();
	ptt_rsp_if rsp ();

	periodic_task_timer_table_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	timer_req_t offer = '0;
	logic       offer_valid = 1'b0;
	logic       take_rsp = 1'b0;

	assign req.valid        = offer_valid;
	assign req.cmd          = offer.cmd;
	assign req.task_key     = offer.key;
	assign req.task_opcode  = offer.opcode;
	assign req.period       = offer.period;
	assign req.repeat_count = offer.rep;
	assign rsp.ready        = take_rsp;

	// shadow of the slot table
	logic               sh_valid     [TASK_SLOTS];
	logic [15:0]        sh_key       [TASK_SLOTS];
	logic [15:0]        sh_opcode    [TASK_SLOTS];
	logic [15:0]        sh_period    [TASK_SLOTS];
	logic [15:0]        sh_elapsed   [TASK_SLOTS];
	logic signed [15:0] sh_remaining [TASK_SLOTS];

	timer_req_t req_backlog [$];
	timer_evt_t timer_events_due [$];

	logic [15:0] key_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};
	logic [15:0] op_pool  [4] = '{16'h0000, 16'hFFFF, 16'h00A5, 16'h7F00};

	int   gap_left = 0;
	int   req_taken = 0;
	logic calm = 1'b0;
	int   rsp_gap = 0;
	int   hold_left = 0;
	logic held_once = 1'b0;
	int   mismatches = 0;
	int   quiet_cycles = 0;

	function automatic timer_evt_t mk_evt(logic [2:0] kind, logic [15:0] key,
			logic [15:0] opcode, logic [4:0] removed);
		timer_evt_t e;
		e.kind    = kind;
		e.key     = key;
		e.opcode  = opcode;
		e.removed = removed;
		e.last    = 1'b0;
		return e;
	endfunction

	function automatic timer_req_t mk_req(logic [1:0] cmd, logic [15:0] key,
			logic [15:0] opcode, logic [15:0] period, logic signed [15:0] rep);
		timer_req_t r;
		r.cmd    = cmd;
		r.key    = key;
		r.opcode = opcode;
		r.period = period;
		r.rep    = rep;
		return r;
	endfunction

	task automatic step_timer_table(input timer_req_t r);
		timer_evt_t evts [$];
		timer_evt_t e;
		int         free_idx;
		int         hits;
		case (r.cmd)
			CMD_TICK: begin
				for (int i = 0; i < TASK_SLOTS; i++) begin
					if (sh_valid[i]) begin
						if (sh_remaining[i] == 0) begin
							sh_valid[i] = 1'b0;
						end else begin
							sh_elapsed[i] = sh_elapsed[i] + 16'd1;
							if (sh_elapsed[i] == sh_period[i]) begin
								if (evts.size() < MAX_RESULTS)
									evts.push_back(mk_evt(KIND_FIRED, sh_key[i],
										sh_opcode[i], '0));
								if (sh_remaining[i] > 0)
									sh_remaining[i] = sh_remaining[i] - 16'sd1;
								sh_elapsed[i] = '0;
							end
							if (sh_remaining[i] == 0)
								sh_valid[i] = 1'b0;
						end
					end
				end
			end
			CMD_ADD: begin
				free_idx = -1;
				for (int i = 0; i < TASK_SLOTS; i++)
					if (!sh_valid[i] && free_idx < 0)
						free_idx = i;
				if (r.period == '0) begin
					evts.push_back(mk_evt(KIND_BAD_PER, r.key, r.opcode, '0));
				end else if (free_idx < 0) begin
					evts.push_back(mk_evt(KIND_FULL, r.key, r.opcode, '0));
				end else begin
					sh_valid[free_idx]     = 1'b1;
					sh_key[free_idx]       = r.key;
					sh_opcode[free_idx]    = r.opcode;
					sh_period[free_idx]    = r.period;
					sh_elapsed[free_idx]   = '0;
					sh_remaining[free_idx] = r.rep;
					evts.push_back(mk_evt(KIND_ADDED, r.key, r.opcode, '0));
				end
			end
			CMD_DEL: begin
				hits = 0;
				for (int i = 0; i < TASK_SLOTS; i++) begin
					if (sh_valid[i] && sh_key[i] == r.key && sh_opcode[i] == r.opcode) begin
						sh_valid[i] = 1'b0;
						hits++;
					end
				end
				evts.push_back(mk_evt(KIND_DELETED, r.key, r.opcode, hits[4:0]));
			end
			default: begin
			end
		endcase
		if (evts.size() > 0) begin
			e = evts.pop_back();
			e.last = 1'b1;
			evts.push_back(e);
		end
		foreach (evts[i])
			timer_events_due.push_back(evts[i]);
	endtask

	function automatic timer_req_t random_request();
		timer_req_t r;
		int         pick;
		int         j;
		pick = $urandom_range(0, 99);
		j = $urandom_range(0, 3);
		r.cmd = (pick < 45) ? CMD_TICK : (pick < 80) ? CMD_ADD :
			(pick < 95) ? CMD_DEL : CMD_RSVD;
		if ($urandom_range(0, 3) != 0) begin
			r.key    = key_pool[j];
			r.opcode = op_pool[j];
		end else begin
			r.key    = 16'($urandom);
			r.opcode = 16'($urandom);
		end
		pick = $urandom_range(0, 19);
		if (pick == 0)
			r.period = '0;
		else if (pick < 15)
			r.period = 16'($urandom_range(1, 4));
		else if (pick < 19)
			r.period = 16'($urandom_range(5, 40));
		else
			r.period = 16'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 2)
			r.rep = REPEAT_FOREVER;
		else if (pick == 2)
			r.rep = '0;
		else if (pick < 8)
			r.rep = 16'($urandom_range(1, 3));
		else if (pick == 8)
			r.rep = 16'($urandom);
		else
			r.rep = 16'($urandom_range(4, 20));
		return r;
	endfunction

	task automatic note_mismatch(input timer_evt_t want, input timer_evt_t got,
			input logic unexpected);
		if (mismatches < 10) begin
			if (unexpected)
				$display("unexpected response: kind %0d key %h op %h removed %0d last %b",
					got.kind, got.key, got.opcode, got.removed, got.last);
			else
				$display("mismatch: exp kind %0d key %h op %h rm %0d last %b, got %0d %h %h %0d %b",
					want.kind, want.key, want.opcode, want.removed, want.last,
					got.kind, got.key, got.opcode, got.removed, got.last);
		end
		mismatches <= mismatches + 1;
	endtask

	initial begin
		int counted;
		timer_req_t r;
		foreach (sh_valid[i])
			sh_valid[i] = 1'b0;

		req_backlog.push_back(mk_req(CMD_ADD, 16'h0000, 16'h0000, 16'd0, 16'sd5));
		req_backlog.push_back(mk_req(CMD_TICK, 16'h0000, 16'h0000, 16'd0, 16'sd0));
		req_backlog.push_back(mk_req(CMD_RSVD, 16'hFFFF, 16'hFFFF, 16'hFFFF, REPEAT_FOREVER));
		req_backlog.push_back(mk_req(CMD_DEL, 16'hFFFF, 16'hFFFF, 16'd0, 16'sd0));
		req_backlog.push_back(mk_req(CMD_ADD, 16'hFFFF, 16'hFFFF, 16'd1, 16'sd2));
		req_backlog.push_back(mk_req(CMD_ADD, 16'h0000, 16'h0000, 16'd1, 16'sd0));
		req_backlog.push_back(mk_req(CMD_ADD, 16'h1234, 16'h4321, 16'd2, REPEAT_FOREVER));
		req_backlog.push_back(mk_req(CMD_ADD, 16'h8001, 16'h7F00, 16'hFFFF, 16'sh7FFF));
		req_backlog.push_back(mk_req(CMD_TICK, 16'h0000, 16'h0000, 16'd0, 16'sd0));
		req_backlog.push_back(mk_req(CMD_TICK, 16'h0000, 16'h0000, 16'd0, 16'sd0));
		// fill the table; most negative repeat count is also unlimited
		req_backlog.push_back(mk_req(CMD_ADD, 16'hA5A5, 16'h5A5A, 16'd1, 16'sh8000));
		repeat (13)
			req_backlog.push_back(mk_req(CMD_ADD, 16'hA5A5, 16'h5A5A, 16'd1, REPEAT_FOREVER));
		req_backlog.push_back(mk_req(CMD_ADD, 16'hBEEF, 16'hCAFE, 16'd3, 16'sd1));
		req_backlog.push_back(mk_req(CMD_ADD, 16'hBEEF, 16'hCAFE, 16'd0, 16'sd1));
		req_backlog.push_back(mk_req(CMD_TICK, 16'h0000, 16'h0000, 16'd0, 16'sd0));
		req_backlog.push_back(mk_req(CMD_DEL, 16'hA5A5, 16'h5A5A, 16'd0, 16'sd0));

		counted = 0;
		while (counted < RANDOM_REQS) begin
			r = random_request();
			req_backlog.push_back(r);
			if (r.cmd != CMD_RSVD)
				counted++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || offer_valid || timer_events_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && timer_events_due.size() == 0)
			$display("periodic_task_timer_table_unit test passed");
		else
			$display("periodic_task_timer_table_unit test failed");
		$finish;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offer_valid <= 1'b0;
			gap_left <= 0;
			req_taken <= 0;
			calm <= 1'b0;
		end else begin
			calm <= (req_backlog.size() < CALM_TAIL);
			if (offer_valid && req.ready) begin
				step_timer_table(offer);
				req_taken <= req_taken + 1;
			end
			if (offer_valid && !req.ready) begin
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				offer_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				if (!calm && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(0, 4);
					offer_valid <= 1'b0;
				end else begin
					offer <= req_backlog.pop_front();
					offer_valid <= 1'b1;
				end
			end else begin
				offer_valid <= 1'b0;
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		timer_evt_t got;
		timer_evt_t want;
		if (!arst_n) begin
			take_rsp <= 1'b0;
			rsp_gap <= 0;
			hold_left <= 0;
			held_once <= 1'b0;
		end else begin
			if (rsp.valid && take_rsp) begin
				got.kind    = rsp.kind;
				got.key     = rsp.out_key;
				got.opcode  = rsp.out_opcode;
				got.removed = rsp.removed_count;
				got.last    = rsp.last;
				if (timer_events_due.size() == 0) begin
					note_mismatch(got, got, 1'b1);
				end else begin
					want = timer_events_due.pop_front();
					if (got !== want)
						note_mismatch(want, got, 1'b0);
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				take_rsp <= 1'b0;
			end else if (!held_once && req_taken >= HOLD_AFTER) begin
				// long back-pressure so the block stalls its request side
				held_once <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				take_rsp <= 1'b0;
			end else if (rsp_gap > 0) begin
				rsp_gap <= rsp_gap - 1;
				take_rsp <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_gap <= $urandom_range(0, 4);
				take_rsp <= 1'b0;
			end else begin
				take_rsp <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("periodic_task_timer_table_unit test failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
